// File: rtl/core/box_blur_3x3_rgb_unit_macros.svh
// Assertion macros used by the checker file of the box blur unit.
// No dependencies; take in with `include before use.
`ifndef BOX_BLUR_3X3_RGB_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_RGB_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BB3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is low
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

// File: rtl/core/bb3_pkg.sv
// Shared constants, types and codes of the 3x3 box blur unit.
// No dependencies; the other files of the block, but for bb3_ram and the macros header, refer to it by scoped names.
package bb3_pkg;

    // Frame geometry
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_DIM      = 2;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Field and counter widths
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = HEIGHT_W;
    localparam int CNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WIDE_W   = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int AREA_W   = WIDTH_W + HEIGHT_W;
    localparam int RESET_LAST_IDX = RESET_WIDTH * RESET_HEIGHT - 1;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    // Front-to-back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result queue
    localparam int ODEPTH = 4;
    localparam int OPTR_W = $clog2(ODEPTH);
    localparam int OCNT_W = $clog2(ODEPTH + 1);

    // Mean by reciprocal multiply: exact for sums up to 9 * 255
    localparam int SUM_W       = $clog2(9 * 255 + 1);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP6      = (2 ** RECIP_SHIFT + 5) / 6;
    localparam int RECIP9      = (2 ** RECIP_SHIFT + 8) / 9;
    localparam int RECIP_W     = $clog2(RECIP6 + 1);
    localparam int MUL_W       = SUM_W + RECIP_W;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } t_div;

    // Classification of one transaction, made by the front
    typedef struct packed {
        logic emit;       // this position yields a result
        logic use_pre;    // result taken from the window before the shift
        logic skip_top;   // top window row lies outside the image
        logic skip_bot;   // bottom window row lies outside the image
        logic skip_left;  // left window column lies outside the image
        logic last;       // final result of the frame
    } t_ctrl;

    typedef struct packed {
        t_ctrl            ctrl;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pix;
    } t_item;

endpackage

// File: rtl/core/box_blur_3x3_rgb_unit.sv
// Top level of the 3x3 edge-clipped box blur on 24-bit RGB pixels.
// Depends on bb3_pkg, bb3_front, bb3_queue and bb3_back.
//
// Usage
//   Input queue side: an item is taken when push is high and full is low. kind = 0
//   carries a pixel in raster order; after the last pixel of a frame send
//   image_width+1 items with kind = 1 to drain the results still pending.
//   Result queue side: the oldest result sits on the outputs while empty is low
//   and is taken when pop is high. o_frame_last marks the last pixel of a frame.
//   Configuration: image_width (index 0) and image_height (index 1) are written
//   through the cfg channel, which is always ready; write them while idle.
// Timing
//   One item per clock sustained while full stays low; the line buffer RAM does one
//   read and one write per item. The result caused by an item passes the read stage,
//   the queue and the sum stage, then the divide writes it into the result queue,
//   from which it reaches the result ports.
//   Results lag the pixel stream by one row plus one pixel.
// Reset
//   Counters and queues clear and the size returns to 640 x 480. The line buffers
//   are not cleared; unwritten entries only fall on clipped window places.
// Stall
//   When pop is held low the 4-entry result queue fills, the back stops, the
//   4-entry middle queue fills and full rises; nothing is dropped.
module box_blur_3x3_rgb_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_kind,
    input  logic [bb3_pkg::CH_W-1:0]        i_in_red,
    input  logic [bb3_pkg::CH_W-1:0]        i_in_green,
    input  logic [bb3_pkg::CH_W-1:0]        i_in_blue,
    output logic                            empty,
    input  logic                            pop,
    output logic [bb3_pkg::CH_W-1:0]        o_out_red,
    output logic [bb3_pkg::CH_W-1:0]        o_out_green,
    output logic [bb3_pkg::CH_W-1:0]        o_out_blue,
    output logic                            o_frame_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                       q_push, q_pop, q_empty;
    bb3_pkg::t_item             q_in, q_out;
    logic [bb3_pkg::QCNT_W-1:0] q_count;

    // Front: counters, line buffers, classification
    bb3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_kind      (i_kind),
        .i_red       (i_in_red),
        .i_green     (i_in_green),
        .i_blue      (i_in_blue),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (q_count),
        .o_q_push    (q_push),
        .o_q_item    (q_in)
    );

    // Decoupling queue
    bb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // Back: window, means, result queue
    bb3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_last    (o_frame_last)
    );

endmodule

// File: rtl/core/bb3_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies. Read during write at the same address returns the old word.
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage and read register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bb3_front.sv
// Front of the box blur: configuration registers, raster counters, line buffers
// and classification of each transaction. Depends on bb3_pkg and bb3_ram.
module bb3_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_kind,
    input  logic [bb3_pkg::CH_W-1:0]       i_red,
    input  logic [bb3_pkg::CH_W-1:0]       i_green,
    input  logic [bb3_pkg::CH_W-1:0]       i_blue,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [bb3_pkg::QCNT_W-1:0]     i_q_count,
    output logic                           o_q_push,
    output bb3_pkg::t_item                 o_q_item
);

    localparam int ROWX_W = bb3_pkg::ROW_W + 1;
    localparam int FULL_W = bb3_pkg::QCNT_W + 1;

    // Configuration, held clamped
    logic [bb3_pkg::WIDTH_W-1:0]  r_width,    n_width;
    logic [bb3_pkg::HEIGHT_W-1:0] r_height,   n_height;
    logic [bb3_pkg::CNT_W-1:0]    r_last_idx, n_last_idx;
    logic [bb3_pkg::WIDTH_W-1:0]  cfg_w;
    logic [bb3_pkg::HEIGHT_W-1:0] cfg_h;
    logic [bb3_pkg::AREA_W-1:0]   cfg_area;

    // Raster position
    logic [bb3_pkg::COL_W-1:0] r_col, n_col, e_col;
    logic [bb3_pkg::ROW_W-1:0] r_row, n_row, e_row;
    logic [bb3_pkg::CNT_W-1:0] r_cnt, n_cnt, e_cnt;
    logic [bb3_pkg::WIDE_W-1:0] width_x, col_inc;
    logic [ROWX_W-1:0]          height_x;
    logic                       restart, wrap, col0, accept;
    bb3_pkg::t_ctrl             ctrl;
    logic [bb3_pkg::PIX_W-1:0]  pix;

    // Read stage
    logic                          r_f1_valid;
    logic [bb3_pkg::COL_W-1:0]     r_f1_col;
    logic [bb3_pkg::PIX_W-1:0]     r_f1_pix;
    bb3_pkg::t_ctrl                r_f1_ctrl;
    logic [2*bb3_pkg::PIX_W-1:0]   ram_rdata;

    assign o_cfg_ready = 1'b1;

    // Register writes with clamping, and the index of the frame's last result
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        cfg_w    = i_cfg_data[bb3_pkg::WIDTH_W-1:0];
        cfg_h    = i_cfg_data[bb3_pkg::HEIGHT_W-1:0];
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bb3_pkg::CFG_IMAGE_WIDTH: begin
                    if (32'(cfg_w) < bb3_pkg::MIN_DIM) begin
                        n_width = bb3_pkg::WIDTH_W'(bb3_pkg::MIN_DIM);
                    end else if (32'(cfg_w) > bb3_pkg::MAX_WIDTH) begin
                        n_width = bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH);
                    end else begin
                        n_width = cfg_w;
                    end
                end
                bb3_pkg::CFG_IMAGE_HEIGHT: begin
                    if (32'(cfg_h) < bb3_pkg::MIN_DIM) begin
                        n_height = bb3_pkg::HEIGHT_W'(bb3_pkg::MIN_DIM);
                    end else if (32'(cfg_h) > bb3_pkg::MAX_HEIGHT) begin
                        n_height = bb3_pkg::HEIGHT_W'(bb3_pkg::MAX_HEIGHT);
                    end else begin
                        n_height = cfg_h;
                    end
                end
                default: begin
                end
            endcase
        end
        cfg_area   = bb3_pkg::AREA_W'(n_width) * bb3_pkg::AREA_W'(n_height);
        n_last_idx = bb3_pkg::CNT_W'(cfg_area - 1'b1);
    end

    // Restart when the position falls outside the frame, then classify
    always_comb begin
        width_x  = bb3_pkg::WIDE_W'(r_width);
        height_x = ROWX_W'(r_height);
        restart  = (bb3_pkg::WIDE_W'(r_col) >= width_x)
                || (ROWX_W'(r_row) > height_x + 1'b1)
                || (r_cnt > r_last_idx);
        e_col = restart ? '0 : r_col;
        e_row = restart ? '0 : r_row;
        e_cnt = restart ? '0 : r_cnt;
        col0  = (e_col == '0);

        ctrl.emit      = (e_row >= bb3_pkg::ROW_W'(2))
                      || ((e_row == bb3_pkg::ROW_W'(1)) && !col0);
        ctrl.use_pre   = col0;
        ctrl.skip_top  = col0 ? (e_row == bb3_pkg::ROW_W'(2)) : (e_row == bb3_pkg::ROW_W'(1));
        ctrl.skip_bot  = col0 ? (ROWX_W'(e_row) == height_x + 1'b1)
                              : (ROWX_W'(e_row) == height_x);
        ctrl.skip_left = col0 || (e_col == bb3_pkg::COL_W'(1));
        ctrl.last      = ctrl.emit && (e_cnt == r_last_idx);

        pix = i_kind ? '0 : {i_red, i_green, i_blue};

        col_inc = bb3_pkg::WIDE_W'(e_col) + 1'b1;
        wrap    = (col_inc >= width_x);
        if (ctrl.last) begin
            n_col = '0;
            n_row = '0;
            n_cnt = '0;
        end else begin
            n_col = wrap ? '0 : bb3_pkg::COL_W'(col_inc);
            n_row = wrap ? e_row + 1'b1 : e_row;
            n_cnt = ctrl.emit ? e_cnt + 1'b1 : e_cnt;
        end
    end

    // Room for this transaction and the one in the read stage
    assign o_full = (FULL_W'(i_q_count) + FULL_W'(r_f1_valid)) >= FULL_W'(bb3_pkg::QDEPTH);
    assign accept = i_push && !o_full;

    // Line buffers: upper row in the high half, middle row in the low half
    bb3_ram #(
        .WIDTH (2 * bb3_pkg::PIX_W),
        .DEPTH (bb3_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid),
        .i_waddr (r_f1_col),
        .i_wdata ({ram_rdata[bb3_pkg::PIX_W-1:0], r_f1_pix}),
        .i_re    (accept),
        .i_raddr (e_col),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= bb3_pkg::WIDTH_W'(bb3_pkg::RESET_WIDTH);
            r_height   <= bb3_pkg::HEIGHT_W'(bb3_pkg::RESET_HEIGHT);
            r_last_idx <= bb3_pkg::CNT_W'(bb3_pkg::RESET_LAST_IDX);
            r_col      <= '0;
            r_row      <= '0;
            r_cnt      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_last_idx <= n_last_idx;
            r_f1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_cnt <= n_cnt;
            end
        end
    end

    // Read stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_col  <= e_col;
            r_f1_pix  <= pix;
            r_f1_ctrl <= ctrl;
        end
    end

    // Transaction to the back
    assign o_q_push      = r_f1_valid;
    assign o_q_item.ctrl = r_f1_ctrl;
    assign o_q_item.up   = ram_rdata[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
    assign o_q_item.mid  = ram_rdata[bb3_pkg::PIX_W-1:0];
    assign o_q_item.pix  = r_f1_pix;

endmodule

// File: rtl/core/bb3_queue.sv
// Short queue between the front and the back of the box blur.
// Depends on bb3_pkg.
module bb3_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  bb3_pkg::t_item             i_item,
    input  logic                       i_pop,
    output bb3_pkg::t_item             o_item,
    output logic                       o_empty,
    output logic [bb3_pkg::QCNT_W-1:0] o_count
);

    bb3_pkg::t_item                r_mem [bb3_pkg::QDEPTH];
    logic [bb3_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [bb3_pkg::QCNT_W-1:0]    r_count;
    logic                          do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_item  = r_mem[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == bb3_pkg::QPTR_W'(bb3_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == bb3_pkg::QPTR_W'(bb3_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + bb3_pkg::QCNT_W'(i_push) - bb3_pkg::QCNT_W'(do_pop);
        end
    end

    // Entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// File: rtl/core/bb3_back.sv
// Back of the box blur: 3x3 window, clipped sums, mean by reciprocal multiply
// and the result queue. Depends on bb3_pkg.
module bb3_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bb3_pkg::t_item           i_q_item,
    input  logic                     i_q_empty,
    output logic                     o_q_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic [bb3_pkg::CH_W-1:0] o_red,
    output logic [bb3_pkg::CH_W-1:0] o_green,
    output logic [bb3_pkg::CH_W-1:0] o_blue,
    output logic                     o_last
);

    localparam int ROOM_W = bb3_pkg::OCNT_W + 1;

    typedef struct packed {
        logic [bb3_pkg::CH_W-1:0] red;
        logic [bb3_pkg::CH_W-1:0] green;
        logic [bb3_pkg::CH_W-1:0] blue;
        logic                     last;
    } t_result;

    // Window: [row][column], column 2 newest
    logic [bb3_pkg::PIX_W-1:0] r_win  [3][3];
    logic [bb3_pkg::PIX_W-1:0] win_sh [3][3];

    // Sum stage
    logic                      take;
    logic [bb3_pkg::SUM_W-1:0] sum    [3];
    bb3_pkg::t_div             div;
    logic                      r_s1_valid;
    logic [bb3_pkg::SUM_W-1:0] r_s1_sum [3];
    bb3_pkg::t_div             r_s1_div;
    logic                      r_s1_last;

    // Divide stage and result queue
    logic [bb3_pkg::MUL_W-1:0] prod [3];
    logic [bb3_pkg::CH_W-1:0]  quot [3];
    t_result                   r_ofifo [bb3_pkg::ODEPTH];
    logic [bb3_pkg::OPTR_W-1:0] r_owptr, r_orptr;
    logic [bb3_pkg::OCNT_W-1:0] r_ocount;
    logic                      out_pop;
    t_result                   head;

    // Take a transaction only if its result has a guaranteed slot
    assign take = !i_q_empty
               && ((ROOM_W'(r_ocount) + ROOM_W'(r_s1_valid)) < ROOM_W'(bb3_pkg::ODEPTH));
    assign o_q_pop = take;

    // Shifted window with the new column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_sh[r][0] = r_win[r][1];
            win_sh[r][1] = r_win[r][2];
        end
        win_sh[0][2] = i_q_item.up;
        win_sh[1][2] = i_q_item.mid;
        win_sh[2][2] = i_q_item.pix;
    end

    // Clipped sums per channel, and the divisor
    always_comb begin
        logic [bb3_pkg::PIX_W-1:0] src;
        logic                      incl;
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
        end
        src  = '0;
        incl = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                src  = i_q_item.ctrl.use_pre ? r_win[r][c] : win_sh[r][c];
                incl = !(i_q_item.ctrl.skip_top && (r == 0))
                    && !(i_q_item.ctrl.skip_bot && (r == 2))
                    && !(i_q_item.ctrl.skip_left && (c == 0));
                if (incl) begin
                    sum[0] = sum[0] + bb3_pkg::SUM_W'(src[3*bb3_pkg::CH_W-1:2*bb3_pkg::CH_W]);
                    sum[1] = sum[1] + bb3_pkg::SUM_W'(src[2*bb3_pkg::CH_W-1:bb3_pkg::CH_W]);
                    sum[2] = sum[2] + bb3_pkg::SUM_W'(src[bb3_pkg::CH_W-1:0]);
                end
            end
        end
        if ((i_q_item.ctrl.skip_top || i_q_item.ctrl.skip_bot) && i_q_item.ctrl.skip_left) begin
            div = bb3_pkg::DIV4;
        end else if (i_q_item.ctrl.skip_top || i_q_item.ctrl.skip_bot
                     || i_q_item.ctrl.skip_left) begin
            div = bb3_pkg::DIV6;
        end else begin
            div = bb3_pkg::DIV9;
        end
    end

    // Truncated mean: shift for four, reciprocal multiply for six and nine
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = '0;
            unique case (r_s1_div)
                bb3_pkg::DIV4: begin
                    quot[k] = bb3_pkg::CH_W'(r_s1_sum[k] >> 2);
                end
                bb3_pkg::DIV6: begin
                    prod[k] = bb3_pkg::MUL_W'(r_s1_sum[k]) * bb3_pkg::MUL_W'(bb3_pkg::RECIP6);
                    quot[k] = bb3_pkg::CH_W'(prod[k] >> bb3_pkg::RECIP_SHIFT);
                end
                bb3_pkg::DIV9: begin
                    prod[k] = bb3_pkg::MUL_W'(r_s1_sum[k]) * bb3_pkg::MUL_W'(bb3_pkg::RECIP9);
                    quot[k] = bb3_pkg::CH_W'(prod[k] >> bb3_pkg::RECIP_SHIFT);
                end
                default: begin
                    quot[k] = '0;
                end
            endcase
        end
    end

    assign out_pop = i_pop && (r_ocount != '0);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_s1_valid <= 1'b0;
            r_owptr    <= '0;
            r_orptr    <= '0;
            r_ocount   <= '0;
        end else begin
            if (take) begin
                r_win <= win_sh;
            end
            r_s1_valid <= take && i_q_item.ctrl.emit;
            if (r_s1_valid) begin
                r_owptr <= (r_owptr == bb3_pkg::OPTR_W'(bb3_pkg::ODEPTH - 1)) ? '0
                                                                            : r_owptr + 1'b1;
            end
            if (out_pop) begin
                r_orptr <= (r_orptr == bb3_pkg::OPTR_W'(bb3_pkg::ODEPTH - 1)) ? '0
                                                                            : r_orptr + 1'b1;
            end
            r_ocount <= r_ocount + bb3_pkg::OCNT_W'(r_s1_valid) - bb3_pkg::OCNT_W'(out_pop);
        end
    end

    // Sum stage payload and result entries
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_sum  <= sum;
            r_s1_div  <= div;
            r_s1_last <= i_q_item.ctrl.last;
        end
        if (r_s1_valid) begin
            r_ofifo[r_owptr] <= '{red: quot[0], green: quot[1], blue: quot[2], last: r_s1_last};
        end
    end

    // Oldest result
    assign head    = r_ofifo[r_orptr];
    assign o_empty = (r_ocount == '0);
    assign o_red   = head.red;
    assign o_green = head.green;
    assign o_blue  = head.blue;
    assign o_last  = head.last;

endmodule

// File: rtl/core/bb3_checker.sv
// Port-level checks of the box blur unit, bound to the top level below.
// Depends on bb3_pkg and box_blur_3x3_rgb_unit_macros.svh.
`include "box_blur_3x3_rgb_unit_macros.svh"

module bb3_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_push,
    input logic                     i_full,
    input logic                     i_empty,
    input logic                     i_pop,
    input logic [bb3_pkg::CH_W-1:0] i_out_red,
    input logic [bb3_pkg::CH_W-1:0] i_out_green,
    input logic [bb3_pkg::CH_W-1:0] i_out_blue,
    input logic                     i_frame_last
);

    // Queues come out of reset empty
    `BB3_ASSERT_IMPL(a_empty_after_reset, i_clk, i_rst_n, $rose(i_rst_n), i_empty)

    // Input side open right after reset
    `BB3_ASSERT_IMPL(a_open_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !i_full)

    // No result before the four-stage path can deliver one
    `BB3_ASSERT_IMPL(a_min_latency, i_clk, i_rst_n, $rose(i_rst_n), ##3 i_empty)

    // A waiting result holds until taken
    `BB3_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable({i_out_red, i_out_green, i_out_blue, i_frame_last}))

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_push       (push),
    .i_full       (full),
    .i_empty      (empty),
    .i_pop        (pop),
    .i_out_red    (o_out_red),
    .i_out_green  (o_out_green),
    .i_out_blue   (o_out_blue),
    .i_frame_last (o_frame_last)
);
